@@ src/sbm_pkg.sv @@
// Shared types and constants for the serial-loaded bank mapper.
// No dependencies; used by every module under src.
`default_nettype none

package sbm_pkg;

    localparam int MAX_PRG_ROM_BANKS = 32;
    localparam int MAX_PRG_RAM_BANKS = 4;
    localparam int MAX_CHR_BANKS     = 32;

    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_OFF  = 3'd1,
        TGT_RAM  = 3'd2,
        TGT_ROM  = 3'd3,
        TGT_CHR  = 3'd4,
        TGT_REG  = 3'd5
    } t_target;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_ROM_BANKS = 3'd0,
        CFG_PRG_RAM_BANKS = 3'd1,
        CFG_NV_RAM_FIRST  = 3'd2,
        CFG_CHR_BANKS     = 3'd3,
        CFG_CHR_IS_RAM    = 3'd4,
        CFG_START_MIRROR  = 3'd5
    } t_cfg_idx;

    // classified bus access as it travels from front to back
    typedef struct packed {
        t_target     cls;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qh;

endpackage

`default_nettype wire

@@ src/sbm_req_if.sv @@
// Request channel of the bank mapper: one bus access per item.
// Standalone; no package use.
`default_nettype none

interface sbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;

    modport source (output valid, kind, bus_address, write_byte, input ready);
    modport sink   (input valid, kind, bus_address, write_byte, output ready);
endinterface

`default_nettype wire

@@ src/sbm_rsp_if.sv @@
// Result channel of the bank mapper: one mapped access per item.
// Standalone; no package use.
`default_nettype none

interface sbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [18:0] phys_offset;
    logic        mem_write;
    logic [7:0]  mem_data;
    logic        nv_write;
    logic [14:0] save_offset;
    logic [1:0]  mirror_mode;

    modport source (output valid, target, phys_offset, mem_write, mem_data, nv_write,
                    save_offset, mirror_mode, input ready);
    modport sink   (input valid, target, phys_offset, mem_write, mem_data, nv_write,
                    save_offset, mirror_mode, output ready);
endinterface

`default_nettype wire

@@ src/sbm_front.sv @@
// Front end: takes bus accesses and sorts them by address region.
// Depends on sbm_pkg and sbm_req_if.
`default_nettype none

module sbm_front (
    sbm_req_if.sink       i_req,
    input  wire logic     i_full,
    output sbm_pkg::t_qh  o_push
);

    localparam logic [1:0] KIND_CPU_RD = 2'd0;
    localparam logic [1:0] KIND_CPU_WR = 2'd1;
    localparam logic [1:0] KIND_PPU_RD = 2'd2;
    localparam logic [1:0] KIND_PPU_WR = 2'd3;

    sbm_pkg::t_target cls;

    always_comb begin
        cls = sbm_pkg::TGT_NONE;
        case (i_req.kind)
            KIND_CPU_RD, KIND_CPU_WR: begin
                if (i_req.bus_address < 16'h4020) begin
                    cls = sbm_pkg::TGT_NONE;
                end else if (i_req.bus_address < 16'h6000) begin
                    cls = sbm_pkg::TGT_OFF;
                end else if (i_req.bus_address < 16'h8000) begin
                    cls = sbm_pkg::TGT_RAM;
                end else if (i_req.kind == KIND_CPU_RD) begin
                    cls = sbm_pkg::TGT_ROM;
                end else begin
                    cls = sbm_pkg::TGT_REG;
                end
            end
            KIND_PPU_RD, KIND_PPU_WR: begin
                cls = (i_req.bus_address < 16'h2000) ? sbm_pkg::TGT_CHR : sbm_pkg::TGT_NONE;
            end
            default: cls = sbm_pkg::TGT_NONE;
        endcase
    end

    assign i_req.ready     = !i_full;
    assign o_push.valid     = i_req.valid && !i_full;
    assign o_push.item.cls  = cls;
    assign o_push.item.wr   = i_req.kind[0];
    assign o_push.item.addr = i_req.bus_address;
    assign o_push.item.data = i_req.write_byte;

endmodule

`default_nettype wire

@@ src/sbm_queue.sv @@
// Two-entry queue between the front end and the mapping back end.
// Depends on sbm_pkg.
`default_nettype none

module sbm_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  sbm_pkg::t_qh i_push,
    output logic         o_full,
    output sbm_pkg::t_qh o_head,
    input  wire logic    i_pop
);

    sbm_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_full      = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !(i_pop && o_head.valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push.valid && i_pop && o_head.valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.valid) begin
                r_wp <= !r_wp;
            end
            if (i_pop && o_head.valid) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

@@ src/sbm_back.sv @@
// Back end: mapper state, bank selection, bank wrap and result register.
// Depends on sbm_pkg and sbm_rsp_if.
`default_nettype none

module sbm_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  sbm_pkg::t_qh                         i_head,
    output logic                                 o_pop,
    sbm_rsp_if.source                            o_rsp
);

    localparam logic [1:0] PRG_32K_A     = 2'd0;
    localparam logic [1:0] PRG_32K_B     = 2'd1;
    localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_FIX_LAST  = 2'd3;
    localparam logic [1:0] SEL_CTRL      = 2'd0;
    localparam logic [1:0] SEL_CHR_LO    = 2'd1;
    localparam logic [1:0] SEL_CHR_HI    = 2'd2;
    localparam logic [1:0] SEL_PRG       = 2'd3;
    localparam logic [1:0] MIR_VERTICAL  = 2'd2;
    localparam logic [4:0] SHIFT_EMPTY   = 5'h10;
    localparam logic [4:0] OUTER_PRESET  = 5'h10;

    typedef struct packed {
        sbm_pkg::t_target tgt;
        logic [4:0]       raw;
        logic [5:0]       modn;
        logic [13:0]      off;
        logic             mw;
        logic [7:0]       data;
        logic [1:0]       mirror;
    } t_s2;

    typedef struct packed {
        sbm_pkg::t_target target;
        logic [18:0]      phys_offset;
        logic             mem_write;
        logic [7:0]       mem_data;
        logic             nv_write;
        logic [14:0]      save_offset;
        logic [1:0]       mirror_mode;
    } t_rsp;

    // configuration
    logic [5:0] r_prg_rom_banks, n_prg_rom_banks;
    logic [2:0] r_prg_ram_banks, n_prg_ram_banks;
    logic [2:0] r_nv_first,      n_nv_first;
    logic [5:0] r_chr_banks,     n_chr_banks;
    logic       r_chr_is_ram,    n_chr_is_ram;
    // mapper state
    logic [4:0] r_shift,  n_shift;
    logic [1:0] r_prg_mode, n_prg_mode;
    logic       r_chr_mode, n_chr_mode;
    logic [4:0] r_chr_lo, n_chr_lo;
    logic [4:0] r_chr_hi, n_chr_hi;
    logic [4:0] r_prg_bank, n_prg_bank;
    logic [1:0] r_mirror, n_mirror;

    logic       r_s2_valid;
    t_s2        r_s2;
    t_s2        s1;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       n_out;

    sbm_pkg::t_item h;
    logic       out_free;
    logic       s2_free;
    logic       take_reg;
    logic [4:0] loaded;

    logic [5:0] rom_n, rom_nm1, chr_n;
    logic [2:0] ram_n;
    logic       ram_ok;
    logic [1:0] ram_b;
    logic [4:0] rom_bank, rom_lo, rom_hi, rom_raw, chr_raw;

    logic [10:0] rem;
    logic [4:0]  bank;
    logic        nv_hit;

    assign h        = i_head.item;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign o_pop    = i_head.valid && s2_free;
    assign take_reg = o_pop && (h.cls == sbm_pkg::TGT_REG);

    // effective bank counts
    always_comb begin
        if (r_prg_rom_banks == 6'd0) begin
            rom_n = 6'd1;
        end else if (r_prg_rom_banks > 6'(sbm_pkg::MAX_PRG_ROM_BANKS)) begin
            rom_n = 6'(sbm_pkg::MAX_PRG_ROM_BANKS);
        end else begin
            rom_n = r_prg_rom_banks;
        end
        if (r_chr_banks == 6'd0) begin
            chr_n = 6'd1;
        end else if (r_chr_banks > 6'(sbm_pkg::MAX_CHR_BANKS)) begin
            chr_n = 6'(sbm_pkg::MAX_CHR_BANKS);
        end else begin
            chr_n = r_chr_banks;
        end
        if (r_prg_ram_banks > 3'(sbm_pkg::MAX_PRG_RAM_BANKS)) begin
            ram_n = 3'(sbm_pkg::MAX_PRG_RAM_BANKS);
        end else begin
            ram_n = r_prg_ram_banks;
        end
        rom_nm1 = rom_n - 6'd1;
    end

    // RAM bank selection and disable rules
    always_comb begin
        ram_ok = (ram_n != 3'd0) && !r_prg_bank[4]
              && !(r_chr_lo[4] && (rom_n <= 6'd16) && (chr_n == 6'd2)
                   && r_chr_is_ram && (ram_n == 3'd1));
        if ((ram_n == 3'd2) && (r_nv_first == 3'd1) && (chr_n >= 6'd4)) begin
            ram_b = {1'b0, r_chr_lo[4]};
        end else begin
            ram_b = {(ram_n == 3'd4) && r_chr_lo[2], (ram_n >= 3'd2) && r_chr_lo[3]};
        end
    end

    // PRG and CHR bank before wrap
    always_comb begin
        rom_bank = {(rom_n == 6'(sbm_pkg::MAX_PRG_ROM_BANKS)) && r_chr_lo[4], r_prg_bank[3:0]};
        case (r_prg_mode)
            PRG_32K_A, PRG_32K_B: begin
                rom_lo = {rom_bank[4:1], 1'b0};
                rom_hi = {rom_bank[4:1], 1'b1};
            end
            PRG_FIX_FIRST: begin
                rom_lo = {rom_bank[4], 4'd0};
                rom_hi = rom_bank;
            end
            PRG_FIX_LAST: begin
                rom_lo = rom_bank;
                rom_hi = {rom_bank[4], rom_nm1[3:0]};
            end
            default: begin
                rom_lo = rom_bank;
                rom_hi = rom_bank;
            end
        endcase
        rom_raw = h.addr[14] ? rom_hi : rom_lo;
        if (!r_chr_mode) begin
            chr_raw = {r_chr_lo[4:1], h.addr[12]};
        end else begin
            chr_raw = h.addr[12] ? r_chr_hi : r_chr_lo;
        end
    end

    // serial port and configuration writes
    always_comb begin
        n_prg_rom_banks = r_prg_rom_banks;
        n_prg_ram_banks = r_prg_ram_banks;
        n_nv_first      = r_nv_first;
        n_chr_banks     = r_chr_banks;
        n_chr_is_ram    = r_chr_is_ram;
        n_shift         = r_shift;
        n_prg_mode      = r_prg_mode;
        n_chr_mode      = r_chr_mode;
        n_chr_lo        = r_chr_lo;
        n_chr_hi        = r_chr_hi;
        n_prg_bank      = r_prg_bank;
        n_mirror        = r_mirror;
        loaded          = {h.data[0], r_shift[4:1]};
        if (take_reg) begin
            if (h.data[7]) begin
                n_shift    = SHIFT_EMPTY;
                n_prg_mode = PRG_FIX_LAST;
            end else if (!r_shift[0]) begin
                n_shift = loaded;
            end else begin
                n_shift = SHIFT_EMPTY;
                case (h.addr[14:13])
                    SEL_CTRL: begin
                        n_mirror   = loaded[1:0];
                        n_prg_mode = loaded[3:2];
                        n_chr_mode = loaded[4];
                    end
                    SEL_CHR_LO: n_chr_lo   = loaded;
                    SEL_CHR_HI: n_chr_hi   = loaded;
                    SEL_PRG:    n_prg_bank = loaded;
                    default:    n_prg_bank = loaded;
                endcase
            end
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                sbm_pkg::CFG_PRG_ROM_BANKS: begin
                    n_prg_rom_banks = i_cfg_data;
                    if (i_cfg_data >= 6'(sbm_pkg::MAX_PRG_ROM_BANKS)) begin
                        n_chr_lo = OUTER_PRESET;
                        n_chr_hi = OUTER_PRESET;
                    end
                end
                sbm_pkg::CFG_PRG_RAM_BANKS: n_prg_ram_banks = i_cfg_data[2:0];
                sbm_pkg::CFG_NV_RAM_FIRST:  n_nv_first      = i_cfg_data[2:0];
                sbm_pkg::CFG_CHR_BANKS:     n_chr_banks     = i_cfg_data;
                sbm_pkg::CFG_CHR_IS_RAM:    n_chr_is_ram    = i_cfg_data[0];
                sbm_pkg::CFG_START_MIRROR:  n_mirror        = i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stage 1: bank, wrap count and in-bank offset
    always_comb begin
        s1.tgt    = h.cls;
        s1.raw    = 5'd0;
        s1.modn   = 6'd1;
        s1.off    = 14'd0;
        s1.mw     = 1'b0;
        s1.data   = h.data;
        s1.mirror = n_mirror;
        case (h.cls)
            sbm_pkg::TGT_RAM: begin
                if (ram_ok) begin
                    s1.raw  = {3'd0, ram_b};
                    s1.modn = {3'd0, ram_n};
                    s1.off  = {1'b0, h.addr[12:0]};
                    s1.mw   = h.wr;
                end else begin
                    s1.tgt = sbm_pkg::TGT_OFF;
                end
            end
            sbm_pkg::TGT_ROM: begin
                s1.raw  = rom_raw;
                s1.modn = rom_n;
                s1.off  = h.addr[13:0];
            end
            sbm_pkg::TGT_CHR: begin
                s1.raw  = chr_raw;
                s1.modn = chr_n;
                s1.off  = {2'd0, h.addr[11:0]};
                s1.mw   = h.wr && r_chr_is_ram;
            end
            default: ;
        endcase
    end

    // stage 2: bank modulo count by restoring subtraction, then offsets
    always_comb begin
        rem = {6'd0, r_s2.raw};
        for (int i = 4; i >= 0; i--) begin
            if (rem >= (11'(r_s2.modn) << i)) begin
                rem = rem - (11'(r_s2.modn) << i);
            end
        end
        bank = rem[4:0];
        nv_hit = (r_s2.tgt == sbm_pkg::TGT_RAM) && r_s2.mw
              && ({1'b0, bank[1:0]} >= r_nv_first);

        n_out.target      = r_s2.tgt;
        n_out.mem_write   = r_s2.mw;
        n_out.mem_data    = r_s2.mw ? r_s2.data : 8'd0;
        n_out.nv_write    = nv_hit;
        n_out.save_offset = nv_hit ? {bank[1:0] - r_nv_first[1:0], r_s2.off[12:0]} : 15'd0;
        n_out.mirror_mode = r_s2.mirror;
        case (r_s2.tgt)
            sbm_pkg::TGT_ROM: n_out.phys_offset = {bank, r_s2.off};
            sbm_pkg::TGT_RAM: n_out.phys_offset = {4'd0, bank[1:0], r_s2.off[12:0]};
            sbm_pkg::TGT_CHR: n_out.phys_offset = {2'd0, bank, r_s2.off[11:0]};
            default:          n_out.phys_offset = 19'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_rom_banks <= 6'd2;
            r_prg_ram_banks <= 3'd0;
            r_nv_first      <= 3'd4;
            r_chr_banks     <= 6'd2;
            r_chr_is_ram    <= 1'b0;
            r_shift         <= SHIFT_EMPTY;
            r_prg_mode      <= PRG_FIX_LAST;
            r_chr_mode      <= 1'b0;
            r_chr_lo        <= 5'd0;
            r_chr_hi        <= 5'd0;
            r_prg_bank      <= 5'd0;
            r_mirror        <= MIR_VERTICAL;
            r_s2_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_prg_rom_banks <= n_prg_rom_banks;
            r_prg_ram_banks <= n_prg_ram_banks;
            r_nv_first      <= n_nv_first;
            r_chr_banks     <= n_chr_banks;
            r_chr_is_ram    <= n_chr_is_ram;
            r_shift         <= n_shift;
            r_prg_mode      <= n_prg_mode;
            r_chr_mode      <= n_chr_mode;
            r_chr_lo        <= n_chr_lo;
            r_chr_hi        <= n_chr_hi;
            r_prg_bank      <= n_prg_bank;
            r_mirror        <= n_mirror;
            if (s2_free) begin
                r_s2_valid <= i_head.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2 <= s1;
        end
        if (out_free && r_s2_valid) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.target      = r_out.target;
    assign o_rsp.phys_offset = r_out.phys_offset;
    assign o_rsp.mem_write   = r_out.mem_write;
    assign o_rsp.mem_data    = r_out.mem_data;
    assign o_rsp.nv_write    = r_out.nv_write;
    assign o_rsp.save_offset = r_out.save_offset;
    assign o_rsp.mirror_mode = r_out.mirror_mode;

    a_marker_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift != 5'd0)
        else $error("shift register lost its marker bit");

    a_reset_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_reg && h.data[7] && !i_cfg_we |=> (r_shift == SHIFT_EMPTY) && (r_prg_mode == PRG_FIX_LAST))
        else $error("reset command did not clear the serial port");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_out_valid && !o_rsp.ready |=> r_s2_valid && $stable(r_s2))
        else $error("stage 2 item changed while the result register was stalled");

    a_nv_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.nv_write |-> r_out.mem_write && (r_out.target == sbm_pkg::TGT_RAM))
        else $error("battery-backed write flagged without a RAM write");

endmodule

`default_nettype wire

@@ src/serial_loaded_bank_mapper.sv @@
// Serial-loaded bank mapper: maps CPU and PPU bus accesses onto PRG-ROM,
// PRG-RAM and CHR offsets. One result per accepted item, in order. The front
// end classifies an access in the cycle it is accepted and writes it into a
// two-entry queue; the back end takes one item per cycle, unless the result
// register is stalled, through two registered stages (bank selection with
// serial register update, then a five-step bank wrap and offset assembly):
// the stage-2 register, then the result register. The sustained rate is one
// item per cycle while results are taken.
// Depends on sbm_pkg, sbm_req_if, sbm_rsp_if, sbm_front, sbm_queue, sbm_back.
`default_nettype none

module serial_loaded_bank_mapper (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    sbm_req_if.sink                              i_req,
    sbm_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sbm_pkg::t_qh push;
    sbm_pkg::t_qh head;
    logic         full;
    logic         pop;

    sbm_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push)
    );

    sbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    sbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ verif/serial_loaded_bank_mapper_test.sv @@
// Self-checking bench for serial_loaded_bank_mapper: a directed table, then random phases.
// Results are matched to the in-bench predictor, or to table values for typed rows.
// Depends on sbm_pkg, sbm_req_if, sbm_rsp_if and the block under src.
`default_nettype none

module serial_loaded_bank_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbm_pkg::*;

    typedef enum logic [1:0] {
        CPU_RD = 2'd0,
        CPU_WR = 2'd1,
        PPU_RD = 2'd2,
        PPU_WR = 2'd3
    } acc_kind_t;

    typedef struct packed {
        t_target     target;
        logic [18:0] phys;
        logic        mw;
        logic [7:0]  md;
        logic        nvw;
        logic [14:0] save;
        logic [1:0]  mirror;
    } map_result_t;

    typedef struct {
        bit          is_reg;
        t_cfg_idx    idx;
        logic [5:0]  val;
        acc_kind_t   k;
        logic [15:0] a;
        logic [7:0]  d;
        bit          typed;
        map_result_t want;
    } plan_row_t;

    localparam int unsigned IO_END   = 16'h4020;
    localparam int unsigned RAM_BASE = 16'h6000;
    localparam int unsigned ROM_BASE = 16'h8000;
    localparam int unsigned CTRL_END = 16'hA000;
    localparam int unsigned CHR0_END = 16'hC000;
    localparam int unsigned CHR1_END = 16'hE000;
    localparam int unsigned CHR_END  = 16'h2000;
    localparam int unsigned REG_SPAN = 16'h2000;
    localparam int unsigned RAM_BANK = 16'h2000;
    localparam int unsigned ROM_BANK = 16'h4000;
    localparam int unsigned CHR_BANK = 16'h1000;

    localparam logic [4:0] SHIFT_EMPTY   = 5'h10;
    localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_FIX_LAST  = 2'd3;
    localparam logic [1:0] MIR_VERTICAL  = 2'd2;

    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int LIMIT       = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sbm_req_if req ();
    sbm_rsp_if rsp ();

    serial_loaded_bank_mapper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of configuration and mapper state
    logic [5:0] cfg_rom       = 6'd2;
    logic [2:0] cfg_ram       = 3'd0;
    logic [2:0] cfg_nv_first  = 3'd4;
    logic [5:0] cfg_chr       = 6'd2;
    logic       cfg_chr_ram   = 1'b0;
    logic [4:0] shifter       = SHIFT_EMPTY;
    logic [1:0] prg_mode_q    = PRG_FIX_LAST;
    logic       chr_mode_q    = 1'b0;
    logic [4:0] chr_lo        = 5'd0;
    logic [4:0] chr_hi        = 5'd0;
    logic [4:0] prg_sel       = 5'd0;
    logic [1:0] mirror_q      = MIR_VERTICAL;

    map_result_t pending_maps[$];
    map_result_t due;
    plan_row_t   plan[$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  cycles       = 0;
    int  hold_left    = 0;
    int  hold_mark    = 300;
    bit  calm         = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_count(int unsigned v, int unsigned top,
                                                int unsigned zero_as);
        if (v == 0) return zero_as;
        return (v > top) ? top : v;
    endfunction

    function automatic int unsigned rom_n();
        return clamp_count(cfg_rom, MAX_PRG_ROM_BANKS, 1);
    endfunction

    function automatic int unsigned chr_n();
        return clamp_count(cfg_chr, MAX_CHR_BANKS, 1);
    endfunction

    // RAM bank for the current board rules, or -1 when RAM is absent or disabled
    function automatic int ram_pick();
        int unsigned n;
        int unsigned b;
        n = clamp_count(cfg_ram, MAX_PRG_RAM_BANKS, 0);
        b = 0;
        if (n == 0 || prg_sel[4]) return -1;
        if (chr_lo[4] && rom_n() <= 16 && chr_n() == 2 && cfg_chr_ram && n == 1) return -1;
        if (n == 2 && cfg_nv_first == 3'd1 && chr_n() >= 4) begin
            b = chr_lo[4];
        end else begin
            if (n >= 2) b |= chr_lo[3];
            if (n == 4) b |= {chr_lo[2], 1'b0};
        end
        return int'(b % n);
    endfunction

    function automatic logic [18:0] rom_phys(logic [15:0] a);
        int unsigned n, bank, lo, hi, off;
        n = rom_n();
        bank = prg_sel[3:0];
        if (n == MAX_PRG_ROM_BANKS) bank |= chr_lo & 5'h10;
        case (prg_mode_q)
            PRG_FIX_FIRST: begin
                lo = bank & 5'h10;
                hi = bank & 5'h1F;
            end
            PRG_FIX_LAST: begin
                lo = bank & 5'h1F;
                hi = (bank & 5'h10) | ((n - 1) & 4'hF);
            end
            default: begin
                lo = bank & 5'h1E;
                hi = lo + 1;
            end
        endcase
        off = a - ROM_BASE;
        if (off < ROM_BANK) return 19'((lo % n) * ROM_BANK + off);
        return 19'((hi % n) * ROM_BANK + off - ROM_BANK);
    endfunction

    function automatic logic [18:0] chr_phys(logic [15:0] a);
        int unsigned n, lo, hi;
        n = chr_n();
        if (!chr_mode_q) begin
            lo = (chr_lo & 5'h1E) % n;
            hi = (lo + 1) % n;
        end else begin
            lo = chr_lo % n;
            hi = chr_hi % n;
        end
        if (a < CHR_BANK) return 19'(lo * CHR_BANK + a);
        return 19'(hi * CHR_BANK + a - CHR_BANK);
    endfunction

    function automatic void shift_in(logic [15:0] a, logic [7:0] d);
        logic [5:0] t;
        if (d[7]) begin
            shifter = SHIFT_EMPTY;
            prg_mode_q = PRG_FIX_LAST;
            return;
        end
        t = {d[0], shifter};
        shifter = t[5:1];
        if (!t[0]) return;
        if (a < CTRL_END) begin
            mirror_q   = shifter[1:0];
            prg_mode_q = shifter[3:2];
            chr_mode_q = shifter[4];
        end else if (a < CHR0_END) begin
            chr_lo = shifter;
        end else if (a < CHR1_END) begin
            chr_hi = shifter;
        end else begin
            prg_sel = shifter;
        end
        shifter = SHIFT_EMPTY;
    endfunction

    function automatic map_result_t map_access(acc_kind_t k, logic [15:0] a, logic [7:0] d);
        map_result_t r;
        int bank;
        r = '0;
        if (k == CPU_RD || k == CPU_WR) begin
            if (a < IO_END) begin
                r.target = TGT_NONE;
            end else if (a < RAM_BASE) begin
                r.target = TGT_OFF;
            end else if (a < ROM_BASE) begin
                bank = ram_pick();
                if (bank < 0) begin
                    r.target = TGT_OFF;
                end else begin
                    r.target = TGT_RAM;
                    r.phys = 19'(bank * RAM_BANK + (a - RAM_BASE));
                    if (k == CPU_WR) begin
                        r.mw = 1'b1;
                        r.md = d;
                        if (bank >= int'(cfg_nv_first)) begin
                            r.nvw = 1'b1;
                            r.save = 15'((bank - cfg_nv_first) * RAM_BANK + (a - RAM_BASE));
                        end
                    end
                end
            end else if (k == CPU_RD) begin
                r.target = TGT_ROM;
                r.phys = rom_phys(a);
            end else begin
                r.target = TGT_REG;
                shift_in(a, d);
            end
        end else if (a < CHR_END) begin
            r.target = TGT_CHR;
            r.phys = chr_phys(a);
            if (k == PPU_WR && cfg_chr_ram) begin
                r.mw = 1'b1;
                r.md = d;
            end
        end
        r.mirror = mirror_q;
        return r;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [5:0] v);
        case (idx)
            CFG_PRG_ROM_BANKS: begin
                cfg_rom = v;
                if (rom_n() == MAX_PRG_ROM_BANKS) begin
                    chr_lo = 5'h10;
                    chr_hi = 5'h10;
                end
            end
            CFG_PRG_RAM_BANKS: cfg_ram = v[2:0];
            CFG_NV_RAM_FIRST:  cfg_nv_first = v[2:0];
            CFG_CHR_BANKS:     cfg_chr = v;
            CFG_CHR_IS_RAM:    cfg_chr_ram = v[0];
            CFG_START_MIRROR:  mirror_q = v[1:0];
            default: ;
        endcase
    endfunction

    function automatic plan_row_t acc_row(acc_kind_t k, logic [15:0] a, logic [7:0] d);
        plan_row_t r;
        r.is_reg = 1'b0;
        r.idx    = CFG_PRG_ROM_BANKS;
        r.val    = '0;
        r.k      = k;
        r.a      = a;
        r.d      = d;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    // expectation read straight off the reset state
    function automatic plan_row_t typed_row(acc_kind_t k, logic [15:0] a, logic [7:0] d,
                                            t_target t, logic [18:0] phys);
        plan_row_t r;
        r = acc_row(k, a, d);
        r.typed = 1'b1;
        r.want.target = t;
        r.want.phys   = phys;
        r.want.mirror = MIR_VERTICAL;
        return r;
    endfunction

    function automatic plan_row_t reg_row(t_cfg_idx idx, logic [5:0] v);
        plan_row_t r;
        r = acc_row(CPU_RD, '0, '0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = v;
        return r;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= 40)
            $display("mismatch at item %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, field, got, want);
    endtask

    task automatic send(acc_kind_t k, logic [15:0] a, logic [7:0] d,
                        bit typed = 1'b0, map_result_t want = '0);
        map_result_t p;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 29) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        req.valid       <= 1'b1;
        req.kind        <= k;
        req.bus_address <= a;
        req.write_byte  <= d;
        forever begin
            @(posedge i_clk);
            if (req.ready) break;
        end
        p = map_access(k, a, d);
        pending_maps.push_back(typed ? want : p);
        items_sent++;
    endtask

    task automatic send_reset_write();
        send(CPU_WR, 16'($urandom_range(ROM_BASE, 16'hFFFF)), 8'h80 | 8'($urandom_range(0, 127)));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [5:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        req.valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic configure(int ph);
        logic [5:0] rom, chr;
        logic [2:0] ram, nv;
        logic       cram;
        logic [1:0] mir;
        case (ph)
            0: {rom, ram, nv, chr, cram, mir} = {6'd2,  3'd0, 3'd4, 6'd2,  1'b0, 2'd2};
            1: {rom, ram, nv, chr, cram, mir} = {6'd32, 3'd4, 3'd2, 6'd32, 1'b1, 2'd0};
            2: {rom, ram, nv, chr, cram, mir} = {6'd16, 3'd1, 3'd0, 6'd2,  1'b1, 2'd3};
            3: {rom, ram, nv, chr, cram, mir} = {6'd16, 3'd2, 3'd1, 6'd8,  1'b0, 2'd1};
            4: {rom, ram, nv, chr, cram, mir} = {6'd0,  3'd7, 3'd7, 6'd0,  1'b1, 2'd2};
            5: {rom, ram, nv, chr, cram, mir} = {6'd63, 3'd3, 3'd5, 6'd63, 1'b0, 2'd3};
            6: {rom, ram, nv, chr, cram, mir} = {6'd33, 3'd4, 3'd0, 6'd16, 1'b1, 2'd1};
            default: begin
                rom  = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(2, 32));
                chr  = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(2, 32));
                ram  = 3'($urandom_range(0, 4));
                nv   = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, ram));
                cram = 1'($urandom);
                mir  = 2'($urandom);
            end
        endcase
        write_reg(CFG_PRG_RAM_BANKS, 6'(ram));
        write_reg(CFG_NV_RAM_FIRST,  6'(nv));
        write_reg(CFG_CHR_BANKS,     chr);
        write_reg(CFG_CHR_IS_RAM,    6'(cram));
        write_reg(CFG_START_MIRROR,  6'(mir));
        write_reg(CFG_PRG_ROM_BANKS, rom);
    endtask

    task automatic random_burst();
        int unsigned pick, region, v;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // five-write register load, now and then broken by a reset write
            v = $urandom_range(0, 31);
            region = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) send_reset_write();
            for (int i = 0; i < 5; i++) begin
                if (i > 0 && $urandom_range(0, 19) == 0) begin
                    send_reset_write();
                end else begin
                    a = (i == 4) ? 16'(ROM_BASE + region * REG_SPAN + $urandom_range(0, REG_SPAN - 1))
                                 : 16'($urandom_range(ROM_BASE, 16'hFFFF));
                    send(CPU_WR, a, {1'b0, 6'($urandom), v[i]});
                end
            end
        end else if (pick < 50) begin
            send(CPU_RD, 16'($urandom_range(ROM_BASE, 16'hFFFF)), 8'($urandom));
        end else if (pick < 65) begin
            send(acc_kind_t'($urandom_range(0, 1)),
                 16'($urandom_range(RAM_BASE, ROM_BASE - 1)), 8'($urandom));
        end else if (pick < 85) begin
            send(acc_kind_t'($urandom_range(2, 3)), 16'($urandom_range(0, CHR_END - 1)),
                 8'($urandom));
        end else begin
            send(acc_kind_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
    endtask

    // result side: ready with random stalls and the occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left == 0 && results_seen >= hold_mark) begin
            hold_left = HOLD_CYCLES;
            hold_mark = hold_mark + 700;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_maps.size() == 0) begin
                report("item with nothing pending, target", rsp.target, 0);
            end else begin
                due = pending_maps.pop_front();
                if (rsp.target !== due.target)      report("target", rsp.target, due.target);
                if (rsp.phys_offset !== due.phys)   report("phys_offset", rsp.phys_offset, due.phys);
                if (rsp.mem_write !== due.mw)       report("mem_write", rsp.mem_write, due.mw);
                if (rsp.mem_data !== due.md)        report("mem_data", rsp.mem_data, due.md);
                if (rsp.nv_write !== due.nvw)       report("nv_write", rsp.nv_write, due.nvw);
                if (rsp.save_offset !== due.save)   report("save_offset", rsp.save_offset, due.save);
                if (rsp.mirror_mode !== due.mirror) report("mirror_mode", rsp.mirror_mode, due.mirror);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending", cycles, pending_maps.size());
            $display("** serial_loaded_bank_mapper: FAILED **");
            $finish;
        end
    end

    initial begin
        int stop;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        req.valid       = 1'b0;
        req.kind        = '0;
        req.bus_address = '0;
        req.write_byte  = '0;
        rsp.ready       = 1'b0;

        plan.push_back(typed_row(CPU_RD, 16'h0000, 8'h00, TGT_NONE, 19'h0));
        plan.push_back(typed_row(CPU_WR, 16'h401F, 8'hFF, TGT_NONE, 19'h0));
        plan.push_back(typed_row(CPU_RD, 16'h4020, 8'h00, TGT_OFF, 19'h0));
        plan.push_back(typed_row(CPU_WR, 16'h7FFF, 8'hFF, TGT_OFF, 19'h0));
        plan.push_back(typed_row(CPU_RD, 16'h8000, 8'h00, TGT_ROM, 19'h0));
        plan.push_back(typed_row(CPU_RD, 16'hFFFF, 8'h00, TGT_ROM, 19'h7FFF));
        plan.push_back(typed_row(PPU_RD, 16'h0000, 8'h00, TGT_CHR, 19'h0));
        plan.push_back(typed_row(PPU_WR, 16'h1FFF, 8'hAA, TGT_CHR, 19'h1FFF));
        plan.push_back(typed_row(PPU_RD, 16'hFFFF, 8'h00, TGT_NONE, 19'h0));
        plan.push_back(typed_row(PPU_WR, 16'h2000, 8'h55, TGT_NONE, 19'h0));
        plan.push_back(typed_row(CPU_WR, 16'h8000, 8'h80, TGT_REG, 19'h0));
        // control = 0x1F: horizontal, last bank fixed, 4K CHR
        plan.push_back(acc_row(CPU_WR, 16'h9FFF, 8'h01));
        plan.push_back(acc_row(CPU_WR, 16'h9FFF, 8'h7F));
        plan.push_back(acc_row(CPU_WR, 16'h9FFF, 8'h01));
        plan.push_back(acc_row(CPU_WR, 16'h9FFF, 8'h41));
        plan.push_back(acc_row(CPU_WR, 16'h9FFF, 8'h01));
        plan.push_back(reg_row(CFG_PRG_ROM_BANKS, 6'd32));
        plan.push_back(reg_row(CFG_PRG_RAM_BANKS, 6'd4));
        plan.push_back(reg_row(CFG_NV_RAM_FIRST,  6'd2));
        plan.push_back(reg_row(CFG_CHR_BANKS,     6'd32));
        plan.push_back(reg_row(CFG_CHR_IS_RAM,    6'd1));
        plan.push_back(reg_row(CFG_START_MIRROR,  6'd0));
        plan.push_back(acc_row(CPU_WR, 16'h6000, 8'h00));
        // CHR bank 0 = 0x0C, selecting the top battery-backed RAM bank
        plan.push_back(acc_row(CPU_WR, 16'hBFFF, 8'h7E));
        plan.push_back(acc_row(CPU_WR, 16'hBFFF, 8'h00));
        plan.push_back(acc_row(CPU_WR, 16'hBFFF, 8'h01));
        plan.push_back(acc_row(CPU_WR, 16'hBFFF, 8'h7F));
        plan.push_back(acc_row(CPU_WR, 16'hBFFF, 8'h00));
        plan.push_back(acc_row(CPU_WR, 16'h7FFF, 8'hFF));
        plan.push_back(acc_row(PPU_WR, 16'h1000, 8'h5A));
        plan.push_back(acc_row(CPU_RD, 16'hC000, 8'h00));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (i == 0 || !plan[i-1].is_reg) settle();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send(plan[i].k, plan[i].a, plan[i].d, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            configure(ph);
            calm = (ph == 3);
            stop = items_sent + PHASE_ITEMS;
            while (items_sent < stop) random_burst();
        end
        calm = 1'b0;
        settle();

        if (errors == 0)
            $display("** serial_loaded_bank_mapper: PASSED **");
        else
            $display("** serial_loaded_bank_mapper: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
